/* hw/rtl/dlsp_pkg.sv */
`default_nettype none
package dlsp_pkg;

  localparam int unsigned AddrWidth   = 29;
  localparam int unsigned CountWidth  = 18;
  localparam int unsigned FetchWidth  = 23;
  localparam int unsigned SnapWidth   = 16;
  localparam int unsigned SegCount    = 16;
  localparam int unsigned SegIdxWidth = 4;

  localparam int unsigned MaxCallDepthDef = 12;
  localparam int unsigned CommandLimitDef = 200000;
  localparam int unsigned MemoryBytesDef  = 8388608;

  localparam logic [7:0] OpReturnLo  = 8'h08;
  localparam logic [7:0] OpReturnHi  = 8'hD2;
  localparam logic [7:0] OpEndDl     = 8'hDF;
  localparam logic [7:0] OpDl        = 8'hDE;
  localparam logic [7:0] OpMoveWord  = 8'hDB;
  localparam logic [7:0] OpScissor   = 8'hED;
  localparam logic [7:0] MoveSegment = 8'h06;

  localparam logic [31:0] ScisLoW0     = 32'hED040020;
  localparam logic [23:0] ScisLoW1     = 24'h4C03A0;
  localparam logic [23:0] ScisLoFullW1 = 24'h5003C0;
  localparam logic [31:0] ScisHiW0     = 32'hED080040;
  localparam logic [23:0] ScisHiW1     = 24'h980740;
  localparam logic [23:0] ScisHiFullW1 = 24'hA00780;
  localparam logic [31:0] ScisFullW0   = 32'hED000000;

  typedef enum logic {
    ST_RUN,
    ST_POP
  } walk_state_e;

  typedef struct packed {
    logic [AddrWidth-1:0]  ptr;
    logic [CountWidth-1:0] cnt;
  } stack_entry_t;

endpackage
`default_nettype wire

/* hw/rtl/dlsp_if.sv */
`default_nettype none
interface dlsp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] list_address;
  logic [31:0] word0;
  logic [31:0] word1;

  modport source (output valid, output op, output list_address, output word0,
                  output word1, input ready);
  modport sink (input valid, input op, input list_address, input word0,
                input word1, output ready);
endinterface

interface dlsp_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] fetch_address;
  logic        walk_done;
  logic        patch_valid;
  logic [22:0] patch_address;
  logic [31:0] patch_word0;
  logic [31:0] patch_word1;
  logic [15:0] snapped_count;

  modport source (output valid, output fetch_address, output walk_done,
                  output patch_valid, output patch_address, output patch_word0,
                  output patch_word1, output snapped_count, input ready);
  modport sink (input valid, input fetch_address, input walk_done,
                input patch_valid, input patch_address, input patch_word0,
                input patch_word1, input snapped_count, output ready);
endinterface

interface dlsp_cfg_if;
  logic valid;
  logic ready;
  logic snap_enable;

  modport source (output valid, output snap_enable, input ready);
  modport sink (input valid, input snap_enable, output ready);
endinterface
`default_nettype wire

/* hw/rtl/display_list_scissor_patcher.sv */
// Display list walker that finds overscan scissors and reports full-frame rewrites.
// in_i carries one word per item: op 0 starts a walk at list_address, op 1 hands in
// the two command words fetched at the last reported fetch_address. out_o returns one
// word per item: next fetch address, walk_done, an optional scissor patch and the
// running patch count. cfg_i writes snap_enable (always ready; write while idle).
// Timing: an accepted item is held in the input register and its result is registered
// in the output register. Each return stack pop the item causes (a return, or a level
// that hits the command limit or runs past memory) adds a wait in the pop state for the
// return stack memory read. Without pops, one item is taken per cycle while the output is free.
// Segment bases and the return stack live in simple dual-port synchronous RAMs; a new
// item's segment lookup is issued on accept and forwarded around a load in flight.
// Reset: walk idle, depth zero, segment table empty, snap_enable 1. No clearing pass.
// A stalled receiver holds the output word; one further item is still taken into
// the input register, then ready drops until the output frees.
`default_nettype none
module display_list_scissor_patcher #(
  parameter int unsigned MAX_CALL_DEPTH = dlsp_pkg::MaxCallDepthDef,
  parameter int unsigned COMMAND_LIMIT  = dlsp_pkg::CommandLimitDef,
  parameter int unsigned MEMORY_BYTES   = dlsp_pkg::MemoryBytesDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  dlsp_in_if.sink      in_i,
  dlsp_cfg_if.sink     cfg_i,
  dlsp_out_if.source   out_o
);

  localparam int unsigned Dw = $clog2(MAX_CALL_DEPTH + 1);
  localparam int unsigned Aw = (MAX_CALL_DEPTH > 1) ? $clog2(MAX_CALL_DEPTH) : 1;
  localparam int unsigned AddrW = dlsp_pkg::AddrWidth;
  localparam int unsigned CntW = dlsp_pkg::CountWidth;
  localparam int unsigned SegW = dlsp_pkg::SegIdxWidth;
  localparam int unsigned StkW = $bits(dlsp_pkg::stack_entry_t);
  localparam logic [Dw-1:0] MaxDepth = Dw'(MAX_CALL_DEPTH);
  localparam logic [CntW-1:0] CmdLimit = CntW'(COMMAND_LIMIT);
  localparam logic [AddrW-1:0] MemBytes = AddrW'(MEMORY_BYTES);

  dlsp_pkg::walk_state_e state_q, state_d;

  logic              item_vld_q, item_vld_d;
  logic              item_op_q;
  logic [31:0]       item_la_q, item_w0_q, item_w1_q;

  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [Dw-1:0]     depth_q, depth_d;
  logic              active_q, active_d;
  logic [15:0]       snap_total_q, snap_total_d;
  logic              snap_en_q;

  logic [dlsp_pkg::SegCount-1:0] seg_valid_q;
  logic              seg_vld_rd_q, seg_fwd_q;
  logic [AddrW-1:0]  seg_fwd_data_q, seg_rdata, seg_base;
  logic              seg_we, seg_clear, seg_hit;
  logic [SegW-1:0]   seg_widx, seg_raddr;
  logic [AddrW-1:0]  seg_wdata;

  logic              stk_we, stk_re, stk_fwd_q;
  logic [Aw-1:0]     stk_raddr;
  dlsp_pkg::stack_entry_t stk_wdata, stk_fwd_data_q, stk_rdata, stk_entry;

  logic              pend_pv_q;
  logic [22:0]       pend_pa_q;
  logic [31:0]       pend_p1_q;

  logic              out_vld_q, out_vld_d;
  logic [22:0]       out_fetch_q, out_pa_q;
  logic              out_done_q, out_pv_q;
  logic [31:0]       out_p0_q, out_p1_q;
  logic [15:0]       out_cnt_q;

  logic              out_room, in_fire, consume, step, leave, check, emit, pv;
  logic [7:0]        code;
  logic [AddrW-1:0]  ptr_adv, phys_w1, phys_start;
  logic [CntW-1:0]   cnt_inc;
  logic [23:0]       pfull;
  logic              emit_pv;
  logic [22:0]       emit_pa;
  logic [31:0]       emit_p1;

  assign out_room = !out_vld_q || out_o.ready;
  assign in_i.ready = !item_vld_q || consume;
  assign in_fire = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign seg_raddr = in_i.word1[27:24];
  assign seg_hit = seg_we && (seg_widx == seg_raddr);
  assign seg_base = !seg_vld_rd_q ? '0 : (seg_fwd_q ? seg_fwd_data_q : seg_rdata);
  assign stk_entry = stk_fwd_q ? stk_fwd_data_q : stk_rdata;

  assign code = item_w0_q[31:24];
  assign ptr_adv = ptr_q + AddrW'(8);
  assign cnt_inc = cnt_q + CntW'(1);
  assign phys_w1 = item_w1_q[31] ? item_w1_q[28:0]
                                 : seg_base + {5'b0, item_w1_q[23:0]};
  assign phys_start = item_la_q[31] ? item_la_q[28:0] : {5'b0, item_la_q[23:0]};

  dlsp_ram #(
    .Width(AddrW),
    .Depth(dlsp_pkg::SegCount)
  ) u_seg_ram (
    .clk_i  (clk_i),
    .we_i   (seg_we),
    .waddr_i(seg_widx),
    .wdata_i(seg_wdata),
    .re_i   (in_fire),
    .raddr_i(seg_raddr),
    .rdata_o(seg_rdata)
  );

  dlsp_ram #(
    .Width(StkW),
    .Depth(MAX_CALL_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(depth_q[Aw-1:0]),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    depth_d = depth_q;
    active_d = active_q;
    snap_total_d = snap_total_q;
    seg_we = 1'b0;
    seg_clear = 1'b0;
    seg_widx = item_w0_q[5:2];
    seg_wdata = item_w1_q[28:0];
    stk_we = 1'b0;
    stk_re = 1'b0;
    stk_raddr = depth_q[Aw-1:0];
    stk_wdata = '{ptr: ptr_adv, cnt: cnt_inc};
    pv = 1'b0;
    pfull = '0;
    leave = 1'b0;
    check = 1'b0;
    emit = 1'b0;
    consume = 1'b0;
    step = 1'b0;

    case (state_q)
      dlsp_pkg::ST_RUN: begin
        if (item_vld_q && out_room) begin
          consume = 1'b1;
          step = 1'b1;
          if (!item_op_q) begin
            seg_clear = 1'b1;
            snap_total_d = '0;
            depth_d = '0;
            cnt_d = '0;
            ptr_d = phys_start;
            active_d = snap_en_q;
            check = snap_en_q;
          end else if (active_q && !snap_en_q) begin
            active_d = 1'b0;
            depth_d = '0;
          end else if (active_q) begin
            if (code inside {[dlsp_pkg::OpReturnLo:dlsp_pkg::OpReturnHi]}) begin
              leave = 1'b1;
            end else begin
              cnt_d = cnt_inc;
              ptr_d = ptr_adv;
              check = 1'b1;
              case (code)
                dlsp_pkg::OpEndDl: begin
                  leave = 1'b1;
                end
                dlsp_pkg::OpDl: begin
                  if (item_w0_q[23:16] != 8'h00) begin
                    ptr_d = phys_w1;
                  end else if (depth_q < MaxDepth) begin
                    stk_we = 1'b1;
                    depth_d = depth_q + Dw'(1);
                    cnt_d = '0;
                    ptr_d = phys_w1;
                  end
                end
                dlsp_pkg::OpMoveWord: begin
                  seg_we = (item_w0_q[23:16] == dlsp_pkg::MoveSegment);
                end
                dlsp_pkg::OpScissor: begin
                  if (item_w0_q == dlsp_pkg::ScisLoW0 &&
                      item_w1_q[23:0] == dlsp_pkg::ScisLoW1) begin
                    pv = 1'b1;
                    pfull = dlsp_pkg::ScisLoFullW1;
                  end else if (item_w0_q == dlsp_pkg::ScisHiW0 &&
                               item_w1_q[23:0] == dlsp_pkg::ScisHiW1) begin
                    pv = 1'b1;
                    pfull = dlsp_pkg::ScisHiFullW1;
                  end
                  if (pv && snap_total_q != 16'hFFFF) begin
                    snap_total_d = snap_total_q + 16'd1;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
      dlsp_pkg::ST_POP: begin
        if (out_room) begin
          step = 1'b1;
          ptr_d = stk_entry.ptr;
          cnt_d = stk_entry.cnt;
          check = 1'b1;
        end
      end
      default: begin
        state_d = dlsp_pkg::ST_RUN;
      end
    endcase

    if (step) begin
      if (leave || (check && (cnt_d >= CmdLimit || ptr_d >= MemBytes))) begin
        if (depth_d == '0) begin
          active_d = 1'b0;
          emit = 1'b1;
          state_d = dlsp_pkg::ST_RUN;
        end else begin
          depth_d = depth_d - Dw'(1);
          stk_re = 1'b1;
          stk_raddr = depth_d[Aw-1:0];
          state_d = dlsp_pkg::ST_POP;
        end
      end else begin
        emit = 1'b1;
        state_d = dlsp_pkg::ST_RUN;
      end
    end
  end

  always_comb begin
    if (state_q == dlsp_pkg::ST_RUN) begin
      emit_pv = pv;
      emit_pa = {ptr_q[22:2], 2'b00};
      emit_p1 = {item_w1_q[31:24], pfull};
    end else begin
      emit_pv = pend_pv_q;
      emit_pa = pend_pa_q;
      emit_p1 = pend_p1_q;
    end
    item_vld_d = in_fire ? 1'b1 : (consume ? 1'b0 : item_vld_q);
    out_vld_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlsp_pkg::ST_RUN;
      item_vld_q <= 1'b0;
      ptr_q <= '0;
      cnt_q <= '0;
      depth_q <= '0;
      active_q <= 1'b0;
      snap_total_q <= '0;
      snap_en_q <= 1'b1;
      seg_valid_q <= '0;
      seg_vld_rd_q <= 1'b0;
      seg_fwd_q <= 1'b0;
      stk_fwd_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      item_vld_q <= item_vld_d;
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      depth_q <= depth_d;
      active_q <= active_d;
      snap_total_q <= snap_total_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        snap_en_q <= cfg_i.snap_enable;
      end
      if (seg_clear) begin
        seg_valid_q <= '0;
      end else if (seg_we) begin
        seg_valid_q[seg_widx] <= 1'b1;
      end
      if (in_fire) begin
        seg_fwd_q <= seg_hit;
        seg_vld_rd_q <= seg_hit || (!seg_clear && seg_valid_q[seg_raddr]);
      end
      if (stk_re) begin
        stk_fwd_q <= stk_we && (stk_raddr == depth_q[Aw-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_op_q <= in_i.op;
      item_la_q <= in_i.list_address;
      item_w0_q <= in_i.word0;
      item_w1_q <= in_i.word1;
      seg_fwd_data_q <= seg_wdata;
    end
    if (stk_re) begin
      stk_fwd_data_q <= stk_wdata;
    end
    if (consume) begin
      pend_pv_q <= pv;
      pend_pa_q <= {ptr_q[22:2], 2'b00};
      pend_p1_q <= {item_w1_q[31:24], pfull};
    end
    if (emit) begin
      out_fetch_q <= active_d ? {ptr_d[22:2], 2'b00} : '0;
      out_done_q <= !active_d;
      out_pv_q <= emit_pv;
      out_pa_q <= emit_pv ? emit_pa : '0;
      out_p0_q <= emit_pv ? dlsp_pkg::ScisFullW0 : '0;
      out_p1_q <= emit_pv ? emit_p1 : '0;
      out_cnt_q <= snap_total_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.fetch_address = out_fetch_q;
  assign out_o.walk_done = out_done_q;
  assign out_o.patch_valid = out_pv_q;
  assign out_o.patch_address = out_pa_q;
  assign out_o.patch_word0 = out_p0_q;
  assign out_o.patch_word1 = out_p1_q;
  assign out_o.snapped_count = out_cnt_q;

  a_idle_depth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> depth_q == '0)
    else $error("call depth nonzero while walk idle");

  a_pop_needs_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dlsp_pkg::ST_POP |-> active_q && depth_q < MaxDepth)
    else $error("stack pop pending without an active nested level");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= MaxDepth)
    else $error("call depth beyond limit");

  a_pop_blocks_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == dlsp_pkg::ST_POP) |-> !consume || !$past(emit))
    else $error("result emitted while a pop was still pending");

endmodule
`default_nettype wire

/* hw/rtl/dlsp_ram.sv */
`default_nettype none
module dlsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire
